[src/spfd_pkg.sv]
// Shared types, constants and helpers for the stereo ping-pong feedback delay.
// No dependencies; every other file imports this package.
package spfd_pkg;

  localparam int LINE_DEPTH  = 262144;
  localparam int SAMPLE_BITS = 24;

  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int FILL_W  = $clog2(LINE_DEPTH + 1);
  localparam int POS_W   = LINE_AW + 8;    // Q.8 read position
  localparam int TGT_W   = LINE_AW + 8;    // Q.8 delay target
  localparam int CD_W    = LINE_AW + 16;   // Q.16 current delay
  localparam int CFG_W   = 26;
  localparam int CFG_AW  = 3;
  localparam int RAMP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int COEF_W  = GAIN_W + 1;
  localparam int ACC_W   = SAMPLE_BITS + 18;
  localparam int SUM_W   = SAMPLE_BITS + 3;
  localparam int DIV_CW  = $clog2(CD_W + 1);

  localparam int INTERP_SHIFT = 8;
  localparam int SCALE_SHIFT  = 15;

  localparam logic [CD_W-1:0]      MIN_TGT   = CD_W'(32 * 256);
  localparam logic [CD_W-1:0]      MAX_TGT   = CD_W'((LINE_DEPTH - 8) * 256);
  localparam logic [POS_W:0]       SPAN      = (POS_W + 1)'(LINE_DEPTH * 256);
  localparam logic [LINE_AW-1:0]   LAST_IDX  = LINE_AW'(LINE_DEPTH - 1);
  localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(LINE_DEPTH);
  localparam logic [8:0]           INTERP_ONE = 9'd256;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (SCALE_SHIFT - 1));

  localparam logic signed [SUM_W-1:0] SMAX =
    SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

  localparam logic [CFG_W-1:0]  RESET_TARGET = CFG_W'(12288000);
  localparam logic [RAMP_W-1:0] RESET_RAMP   = RAMP_W'(4800);
  localparam logic [GAIN_W-1:0] RESET_FB     = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0] RESET_WET    = GAIN_W'(16384);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_word_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_word_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_DELAY_TARGET = 3'd0,
    REG_RAMP_STEPS   = 3'd1,
    REG_FB_GAIN      = 3'd2,
    REG_WET_MIX      = 3'd3,
    REG_PING_PONG    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_ACC  = 2'd1,
    BASE_BIAS = 2'd2
  } mac_base_t;

  typedef struct packed {
    logic      en;
    mac_base_t base;
  } mac_ctl_t;

  // Clamp a Q.8 target into the usable range of the line.
  function automatic logic [TGT_W-1:0] clamp_target(input logic [CFG_W-1:0] t);
    logic [CD_W-1:0] v;
    v = CD_W'(t);
    if (v < MIN_TGT) begin
      v = MIN_TGT;
    end else if (v > MAX_TGT) begin
      v = MAX_TGT;
    end
    return v[TGT_W-1:0];
  endfunction

  localparam logic [TGT_W-1:0] RESET_LAST = clamp_target(RESET_TARGET);

  // x + floor(acc / 2^15), saturated to the sample range; callers fold the rounding bias into acc.
  function automatic sample_t mix(input sample_t x, input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] c;
    sh = acc >>> SCALE_SHIFT;
    s  = SUM_W'(sh) + SUM_W'(x);
    if (s > SMAX) begin
      c = SMAX;
    end else if (s < SMIN) begin
      c = SMIN;
    end else begin
      c = s;
    end
    return SAMPLE_BITS'(c);
  endfunction

endpackage

[src/spfd_line.sv]
// One delay line: single-port sample memory with registered read data.
// Depends on spfd_pkg.
module spfd_line (
  input  logic                          clk,
  input  logic                          we,
  input  logic [spfd_pkg::LINE_AW-1:0]  addr,
  input  spfd_pkg::sample_t             wdata,
  output spfd_pkg::sample_t             rdata
);
  import spfd_pkg::*;

  sample_t mem [LINE_DEPTH];
  sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[src/spfd_mac.sv]
// Shared multiply-accumulate unit: acc = base + a * b, one product per cycle.
// Depends on spfd_pkg.
module spfd_mac (
  input  logic                                 clk,
  input  spfd_pkg::mac_ctl_t                   ctl,
  input  spfd_pkg::sample_t                    mul_a,
  input  logic signed [spfd_pkg::COEF_W-1:0]   mul_b,
  output logic signed [spfd_pkg::ACC_W-1:0]    acc
);
  import spfd_pkg::*;

  logic signed [SAMPLE_BITS+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]              base;
  logic signed [ACC_W-1:0]              acc_r;
  logic signed [ACC_W-1:0]              acc_nxt;

  assign prod = mul_a * mul_b;

  always_comb begin
    case (ctl.base)
      BASE_ZERO: base = '0;
      BASE_ACC:  base = acc_r;
      BASE_BIAS: base = ROUND_BIAS;
      default:   base = '0;
    endcase
    acc_nxt = ctl.en ? (base + ACC_W'(prod)) : acc_r;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[src/spfd_div.sv]
// Restoring divider, one quotient bit per cycle, for the glide step.
// Depends on spfd_pkg.
module spfd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [spfd_pkg::CD_W-1:0]     num,
  input  logic [spfd_pkg::RAMP_W-1:0]   den,
  output logic                          done,
  output logic [spfd_pkg::CD_W-1:0]     quo
);
  import spfd_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [RAMP_W-1:0] rem_r, rem_nxt;
  logic [CD_W-1:0]   quo_r, quo_nxt;

  logic [RAMP_W:0]   shifted;
  logic [RAMP_W+1:0] trial;
  logic              fits;

  always_comb begin
    shifted = {rem_r, quo_r[CD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den};
    fits    = !trial[RAMP_W+1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(CD_W);
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[RAMP_W-1:0] : shifted[RAMP_W-1:0];
      quo_nxt = {quo_r[CD_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CW'(1);
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/stereo_pingpong_feedback_delay_core.sv]
// Top level of the stereo ping-pong feedback delay: sequencer, state, config.
// Depends on spfd_pkg, spfd_line, spfd_mac and spfd_div.
//
//   port group   dir   handshake            word
//   in_*         in    in_valid/in_ready    in_data   (left_in, right_in)
//   out_*        out   out_valid/out_ready  out_data  (left_out, right_out)
//   cfg_*        in    cfg_we               cfg_addr, cfg_wdata
//
// Each word steps through S_TGT, S_GLIDE, S_POS, S_RD0/S_RD1, S_M0-S_M6 (S_M6 twice), S_WR, S_OUT
// before the next accept; a target change with a nonzero ramp adds S_DIV for the bit-serial step divider.
// All eight products go through one shared multiplier; each line is a
// single-port memory read twice and written once per word.
// Reset (synchronous) needs no sweep: entries at or above the fill count read as zero.
// While a result waits in the output register the next word runs up to its line write.
module stereo_pingpong_feedback_delay_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spfd_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spfd_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [spfd_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [spfd_pkg::CFG_W-1:0]    cfg_wdata
);
  import spfd_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_TGT   = 16'h0002,
    S_DIV   = 16'h0004,
    S_GLIDE = 16'h0008,
    S_POS   = 16'h0010,
    S_RD0   = 16'h0020,
    S_RD1   = 16'h0040,
    S_M0    = 16'h0080,
    S_M1    = 16'h0100,
    S_M2    = 16'h0200,
    S_M3    = 16'h0400,
    S_M4    = 16'h0800,
    S_M5    = 16'h1000,
    S_M6    = 16'h2000,
    S_WR    = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  // S_M7 / S_M8 are folded: see the feedback products below.
  state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0]  tgt_cfg_r, tgt_cfg_nxt;
  logic [RAMP_W-1:0] ramp_r, ramp_nxt;
  logic [GAIN_W-1:0] fb_r, fb_nxt;
  logic [GAIN_W-1:0] wet_r, wet_nxt;
  logic              pp_r, pp_nxt;

  // delay state
  logic [TGT_W-1:0]         last_r, last_nxt;
  logic [CD_W-1:0]          cd_r, cd_nxt;
  logic signed [CD_W:0]     step_r, step_nxt;
  logic [RAMP_W-1:0]        gleft_r, gleft_nxt;
  logic                     neg_r, neg_nxt;
  logic [LINE_AW-1:0]       w_r, w_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;

  // per-word working registers
  sample_t            xl_r, xl_nxt, xr_r, xr_nxt;
  logic [LINE_AW-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic [7:0]         f_r, f_nxt;
  sample_t            la_r, la_nxt, lb_r, lb_nxt, ra_r, ra_nxt, rb_r, rb_nxt;
  sample_t            tl_r, tl_nxt, tr_r, tr_nxt;
  sample_t            yl_r, yl_nxt, yr_r, yr_nxt;
  sample_t            wl_r, wl_nxt, wr_r, wr_nxt;
  logic               fbsel_r, fbsel_nxt;   // second feedback product pending

  out_word_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;

  // shared units
  mac_ctl_t                  mac_ctl;
  sample_t                   mul_a;
  logic signed [COEF_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]   acc;

  logic              div_start, div_done;
  logic [CD_W-1:0]   div_num, div_quo;

  logic               line_we;
  logic [LINE_AW-1:0] line_addr;
  sample_t            lrd, rrd;

  // combinational helpers
  logic [TGT_W-1:0]     tgt;
  logic [CD_W-1:0]      tgt_q16;
  logic signed [CD_W:0] diff;
  logic [CD_W-1:0]      diff_mag;
  logic [CD_W-1:0]      cd_glide;
  logic [POS_W-1:0]     cdq;
  logic [POS_W:0]       pos_raw, pos_w;
  logic [LINE_AW-1:0]   pos_r0;
  logic [8:0]           f_inv;
  logic signed [COEF_W-1:0] c_lo, c_hi, c_wet, c_fb;
  logic                 ok0, ok1;

  spfd_line u_left (
    .clk   (clk),
    .we    (line_we),
    .addr  (line_addr),
    .wdata (wl_r),
    .rdata (lrd)
  );

  spfd_line u_right (
    .clk   (clk),
    .we    (line_we),
    .addr  (line_addr),
    .wdata (wr_r),
    .rdata (rrd)
  );

  spfd_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .acc   (acc)
  );

  spfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (ramp_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    tgt      = clamp_target(tgt_cfg_r);
    tgt_q16  = {tgt, 8'h00};
    diff     = $signed({1'b0, tgt_q16}) - $signed({1'b0, cd_r});
    diff_mag = diff[CD_W] ? CD_W'(-diff) : diff[CD_W-1:0];
    cd_glide = CD_W'($signed({1'b0, cd_r}) + step_r);

    // read position = write*256 - delay, wrapped into the line
    cdq     = cd_r[CD_W-1:8];
    pos_raw = {1'b0, w_r, 8'h00} + SPAN - {1'b0, cdq};
    pos_w   = (pos_raw >= SPAN) ? (pos_raw - SPAN) : pos_raw;
    pos_r0  = pos_w[POS_W-1:8];

    f_inv = INTERP_ONE - {1'b0, f_r};
    c_lo  = $signed(COEF_W'(f_inv));
    c_hi  = $signed(COEF_W'(f_r));
    c_wet = $signed({1'b0, wet_r});
    c_fb  = $signed({1'b0, fb_r});

    // entries past the fill count were never written: they read as zero
    ok0 = (FILL_W'(r0_r) < fill_r);
    ok1 = (FILL_W'(r1_r) < fill_r);
  end

  always_comb begin
    state_nxt   = state_r;
    tgt_cfg_nxt = tgt_cfg_r;
    ramp_nxt    = ramp_r;
    fb_nxt      = fb_r;
    wet_nxt     = wet_r;
    pp_nxt      = pp_r;
    last_nxt    = last_r;
    cd_nxt      = cd_r;
    step_nxt    = step_r;
    gleft_nxt   = gleft_r;
    neg_nxt     = neg_r;
    w_nxt       = w_r;
    fill_nxt    = fill_r;
    xl_nxt      = xl_r;
    xr_nxt      = xr_r;
    r0_nxt      = r0_r;
    r1_nxt      = r1_r;
    f_nxt       = f_r;
    la_nxt      = la_r;
    lb_nxt      = lb_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    tl_nxt      = tl_r;
    tr_nxt      = tr_r;
    yl_nxt      = yl_r;
    yr_nxt      = yr_r;
    wl_nxt      = wl_r;
    wr_nxt      = wr_r;
    fbsel_nxt   = fbsel_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    mac_ctl   = '{en: 1'b0, base: BASE_ZERO};
    mul_a     = la_r;
    mul_b     = c_lo;
    div_start = 1'b0;
    div_num   = diff_mag;
    line_we   = 1'b0;
    line_addr = w_r;

    if (cfg_we) begin
      case (cfg_addr)
        REG_DELAY_TARGET: tgt_cfg_nxt = cfg_wdata;
        REG_RAMP_STEPS:   ramp_nxt    = cfg_wdata[RAMP_W-1:0];
        REG_FB_GAIN:      fb_nxt      = cfg_wdata[GAIN_W-1:0];
        REG_WET_MIX:      wet_nxt     = cfg_wdata[GAIN_W-1:0];
        REG_PING_PONG:    pp_nxt      = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          xl_nxt    = in_data.left_in;
          xr_nxt    = in_data.right_in;
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        state_nxt = S_GLIDE;
        if (tgt != last_r) begin
          last_nxt = tgt;
          if (ramp_r == '0) begin
            cd_nxt    = tgt_q16;
            gleft_nxt = '0;
          end else begin
            gleft_nxt = ramp_r;
            neg_nxt   = diff[CD_W];
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // quotient truncates toward zero: divide magnitudes, restore sign
        if (div_done) begin
          step_nxt  = neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          state_nxt = S_GLIDE;
        end
      end
      S_GLIDE: begin
        if (gleft_r != '0) begin
          gleft_nxt = gleft_r - RAMP_W'(1);
          cd_nxt    = (gleft_r == RAMP_W'(1)) ? {last_r, 8'h00} : cd_glide;
        end
        state_nxt = S_POS;
      end
      S_POS: begin
        r0_nxt    = pos_r0;
        r1_nxt    = (pos_r0 == LAST_IDX) ? '0 : pos_r0 + LINE_AW'(1);
        f_nxt     = pos_w[7:0];
        state_nxt = S_RD0;
      end
      S_RD0: begin
        line_addr = r0_r;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        line_addr = r1_r;
        la_nxt    = ok0 ? lrd : '0;
        ra_nxt    = ok0 ? rrd : '0;
        state_nxt = S_M0;
      end
      S_M0: begin
        lb_nxt    = ok1 ? lrd : '0;
        rb_nxt    = ok1 ? rrd : '0;
        mac_ctl   = '{en: 1'b1, base: BASE_ZERO};
        mul_a     = la_r;
        mul_b     = c_lo;
        state_nxt = S_M1;
      end
      S_M1: begin
        mac_ctl   = '{en: 1'b1, base: BASE_ACC};
        mul_a     = lb_r;
        mul_b     = c_hi;
        state_nxt = S_M2;
      end
      S_M2: begin
        tl_nxt    = SAMPLE_BITS'(acc >>> INTERP_SHIFT);
        mac_ctl   = '{en: 1'b1, base: BASE_ZERO};
        mul_a     = ra_r;
        mul_b     = c_lo;
        state_nxt = S_M3;
      end
      S_M3: begin
        mac_ctl   = '{en: 1'b1, base: BASE_ACC};
        mul_a     = rb_r;
        mul_b     = c_hi;
        state_nxt = S_M4;
      end
      S_M4: begin
        tr_nxt    = SAMPLE_BITS'(acc >>> INTERP_SHIFT);
        mac_ctl   = '{en: 1'b1, base: BASE_BIAS};
        mul_a     = tl_r;
        mul_b     = c_wet;
        state_nxt = S_M5;
      end
      S_M5: begin
        yl_nxt    = mix(xl_r, acc);
        mac_ctl   = '{en: 1'b1, base: BASE_BIAS};
        mul_a     = tr_r;
        mul_b     = c_wet;
        fbsel_nxt = 1'b0;
        state_nxt = S_M6;
      end
      S_M6: begin
        // two passes: left feedback product, then right; ping-pong swaps taps
        mac_ctl = '{en: 1'b1, base: BASE_BIAS};
        mul_b   = c_fb;
        if (!fbsel_r) begin
          yr_nxt    = mix(xr_r, acc);
          mul_a     = pp_r ? tr_r : tl_r;
          fbsel_nxt = 1'b1;
        end else begin
          wl_nxt    = mix(xl_r, acc);
          mul_a     = pp_r ? tl_r : tr_r;
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        wr_nxt    = mix(xr_r, acc);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // line write happens here with both feedback words registered
        line_we   = 1'b1;
        line_addr = w_r;
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = '{left_out: yl_r, right_out: yr_r};
          out_valid_nxt = 1'b1;
          w_nxt         = (w_r == LAST_IDX) ? '0 : w_r + LINE_AW'(1);
          if (fill_r != FILL_FULL) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tgt_cfg_r   <= RESET_TARGET;
      ramp_r      <= RESET_RAMP;
      fb_r        <= RESET_FB;
      wet_r       <= RESET_WET;
      pp_r        <= 1'b0;
      last_r      <= RESET_LAST;
      cd_r        <= {RESET_LAST, 8'h00};
      step_r      <= '0;
      gleft_r     <= '0;
      w_r         <= '0;
      fill_r      <= '0;
      fbsel_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_cfg_r   <= tgt_cfg_nxt;
      ramp_r      <= ramp_nxt;
      fb_r        <= fb_nxt;
      wet_r       <= wet_nxt;
      pp_r        <= pp_nxt;
      last_r      <= last_nxt;
      cd_r        <= cd_nxt;
      step_r      <= step_nxt;
      gleft_r     <= gleft_nxt;
      w_r         <= w_nxt;
      fill_r      <= fill_nxt;
      fbsel_r     <= fbsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    xl_r       <= xl_nxt;
    xr_r       <= xr_nxt;
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    f_r        <= f_nxt;
    la_r       <= la_nxt;
    lb_r       <= lb_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    tl_r       <= tl_nxt;
    tr_r       <= tr_nxt;
    yl_r       <= yl_nxt;
    yr_r       <= yr_nxt;
    wl_r       <= wl_nxt;
    wr_r       <= wr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[bench/spfd_checker.sv]
// Checker for the stereo ping-pong delay: watches the word and config ports,
// predicts each output word and compares it field by field. Needs spfd_pkg.
module spfd_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  spfd_pkg::in_word_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  spfd_pkg::out_word_t         out_data,
  input  logic                        cfg_we,
  input  logic [spfd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [spfd_pkg::CFG_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          words_in_flight
);
  import spfd_pkg::*;

  localparam longint LINE_SPAN = longint'(LINE_DEPTH) * 256;
  localparam longint TGT_FLOOR = 32 * 256;
  localparam longint TGT_CEIL  = longint'(LINE_DEPTH - 8) * 256;
  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

  // delay lines and glide state
  sample_t left_mem  [LINE_DEPTH];
  sample_t right_mem [LINE_DEPTH];
  int      wr_idx;
  longint  cur_delay;    // Q.16
  longint  glide_inc;    // Q.16, signed
  int      glide_cnt;
  longint  tgt_prev;     // Q.8, clamped

  // register shadow
  logic [CFG_W-1:0] tgt_reg;
  int               ramp_reg;
  int               fb_reg;
  int               wet_reg;
  logic             pp_reg;

  out_word_t pending_mix [$];
  int        errs;

  function automatic longint clamp_q8(longint t);
    if (t < TGT_FLOOR) return TGT_FLOOR;
    if (t > TGT_CEIL) return TGT_CEIL;
    return t;
  endfunction

  function automatic longint clip_sample(longint x);
    if (x > SAMPLE_HI) return SAMPLE_HI;
    if (x < SAMPLE_LO) return SAMPLE_LO;
    return x;
  endfunction

  // Q1.15 gain, round half up
  function automatic longint apply_gain(longint x, int g);
    return (x * longint'(g) + 16384) >>> 15;
  endfunction

  // One stereo pair through the delay: advances the glide, reads both taps,
  // writes the lines and returns the mixed output word.
  function automatic out_word_t process_pair(in_word_t w);
    longint    tgt;
    longint    pos;
    longint    dry_l, dry_r, tap_l, tap_r, fb_l, fb_r;
    int        r0, r1, frac;
    out_word_t res;
    dry_l = longint'(w.left_in);
    dry_r = longint'(w.right_in);
    tgt   = clamp_q8(longint'(tgt_reg));
    if (tgt != tgt_prev) begin
      tgt_prev = tgt;
      if (ramp_reg == 0) begin
        cur_delay = tgt << 8;
        glide_cnt = 0;
      end else begin
        glide_cnt = ramp_reg;
        glide_inc = ((tgt << 8) - cur_delay) / longint'(ramp_reg);
      end
    end
    if (glide_cnt != 0) begin
      glide_cnt--;
      if (glide_cnt == 0) begin
        cur_delay = tgt_prev << 8;
      end else begin
        cur_delay = cur_delay + glide_inc;
      end
    end
    pos = longint'(wr_idx) * 256 + LINE_SPAN - (cur_delay >>> 8);
    if (pos >= LINE_SPAN) begin
      pos = pos - LINE_SPAN;
    end
    r0   = int'(pos >>> 8);
    frac = int'(pos & 255);
    r1   = (r0 == LINE_DEPTH - 1) ? 0 : r0 + 1;
    tap_l = (longint'(left_mem[r0]) * longint'(256 - frac)
             + longint'(left_mem[r1]) * longint'(frac)) >>> 8;
    tap_r = (longint'(right_mem[r0]) * longint'(256 - frac)
             + longint'(right_mem[r1]) * longint'(frac)) >>> 8;
    fb_l = pp_reg ? tap_r : tap_l;
    fb_r = pp_reg ? tap_l : tap_r;
    left_mem[wr_idx]  = sample_t'(clip_sample(dry_l + apply_gain(fb_l, fb_reg)));
    right_mem[wr_idx] = sample_t'(clip_sample(dry_r + apply_gain(fb_r, fb_reg)));
    res.left_out  = sample_t'(clip_sample(dry_l + apply_gain(tap_l, wet_reg)));
    res.right_out = sample_t'(clip_sample(dry_r + apply_gain(tap_r, wet_reg)));
    wr_idx = (wr_idx == LINE_DEPTH - 1) ? 0 : wr_idx + 1;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        left_mem[i]  = '0;
        right_mem[i] = '0;
      end
      wr_idx    = 0;
      tgt_reg   = RESET_TARGET;
      ramp_reg  = int'(RESET_RAMP);
      fb_reg    = int'(RESET_FB);
      wet_reg   = int'(RESET_WET);
      pp_reg    = 1'b0;
      tgt_prev  = clamp_q8(longint'(RESET_TARGET));
      cur_delay = tgt_prev << 8;
      glide_inc = 0;
      glide_cnt = 0;
      errs      = 0;
      pending_mix.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_mix.size() == 0) begin
          $error("output word with no input word waiting: left_out %0d right_out %0d",
                 got.left_out, got.right_out);
          errs++;
        end else begin
          want = pending_mix.pop_front();
          if (got.left_out !== want.left_out) begin
            $error("left_out mismatch: expected %0d, got %0d", want.left_out, got.left_out);
            errs++;
          end
          if (got.right_out !== want.right_out) begin
            $error("right_out mismatch: expected %0d, got %0d",
                   want.right_out, got.right_out);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_mix.push_back(process_pair(in_data));
      end
      // writes count from the next word on
      if (cfg_we) begin
        case (cfg_addr)
          REG_DELAY_TARGET: tgt_reg  = cfg_wdata;
          REG_RAMP_STEPS:   ramp_reg = int'(cfg_wdata[RAMP_W-1:0]);
          REG_FB_GAIN:      fb_reg   = int'(cfg_wdata[GAIN_W-1:0]);
          REG_WET_MIX:      wet_reg  = int'(cfg_wdata[GAIN_W-1:0]);
          REG_PING_PONG:    pp_reg   = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    fail_count      <= errs;
    words_in_flight <= pending_mix.size();
  end

endmodule

[bench/testbench.sv]
// Top of the bench for stereo_pingpong_feedback_delay_core: clock, reset,
// stimulus, output back-pressure, watchdog and verdict. Needs spfd_pkg and spfd_checker.
module testbench;
  import spfd_pkg::*;

  // Receiver drops out_ready for a LONG_HOLD hold-off after every HOLD_WORDS words (twice),
  // so the core fills up and drops in_ready while words keep being offered.
  localparam int HOLD_WORDS     = 400;
  localparam int LONG_HOLD      = 500;
  // Slowest legal gap between two handshakes: long hold + word time + divider +
  // longest sender gap, taken several times over.
  localparam int WATCHDOG_LIMIT = 4000;
  // Tail after the last word: a word time plus the step divider, padded.
  localparam int QUIET_CYCLES   = 64;
  localparam int RANDOM_WORDS   = 1150;

  // First address past the register map; writes there must be dropped.
  localparam logic [CFG_AW-1:0] REG_SPARE = CFG_AW'(REG_PING_PONG + 1);

  typedef struct packed {
    logic [CFG_W-1:0]  target;
    logic [RAMP_W-1:0] ramp;
    logic [GAIN_W-1:0] fb;
    logic [GAIN_W-1:0] wet;
    logic              pp;
    logic              spare;   // also poke the unused addresses
  } delay_setup_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_W-1:0]    cfg_wdata;

  int fail_count;
  int words_in_flight;

  // sender / receiver / watchdog bookkeeping
  bit sender_calm;
  int stall_left;
  int burst_left;
  int words_taken;
  int holds_done;
  int ready_pick;
  int quiet_count;

  stereo_pingpong_feedback_delay_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  spfd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .words_in_flight (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- helpers

  // Full-scale corners plus alternating bit patterns.
  function automatic sample_t corner_value(int k);
    case (k % 7)
      0: return sample_t'(24'h7FFFFF);
      1: return sample_t'(24'h800000);
      2: return sample_t'(24'h000000);
      3: return sample_t'(24'hFFFFFF);
      4: return sample_t'(24'h000001);
      5: return sample_t'(24'h555555);
      default: return sample_t'(24'hAAAAAA);
    endcase
  endfunction

  // Left and right are offset so the pair mixes different corners.
  function automatic in_word_t corner_word(int k);
    in_word_t w;
    w.left_in  = corner_value(k);
    w.right_in = corner_value(k + 3);
    return w;
  endfunction

  // Random pair: mostly full-range noise, some quiet material, some corners
  // and some near-full-scale bursts to push the sums into saturation.
  function automatic in_word_t noise_word();
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      w.left_in  = sample_t'($urandom);
      w.right_in = sample_t'($urandom);
    end else if (r < 78) begin
      w.left_in  = sample_t'(int'($urandom_range(0, 8191)) - 4096);
      w.right_in = sample_t'(int'($urandom_range(0, 8191)) - 4096);
    end else if (r < 90) begin
      w = corner_word($urandom_range(0, 6));
    end else begin
      w.left_in  = sample_t'({($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 22'($urandom)});
      w.right_in = sample_t'({($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 22'($urandom)});
    end
    return w;
  endfunction

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic delay_setup_t make_setup(logic [CFG_W-1:0] target,
                                              logic [RAMP_W-1:0] ramp,
                                              logic [GAIN_W-1:0] fb,
                                              logic [GAIN_W-1:0] wet,
                                              logic pp, logic spare);
    delay_setup_t s;
    s.target = target;
    s.ramp   = ramp;
    s.fb     = fb;
    s.wet    = wet;
    s.pp     = pp;
    s.spare  = spare;
    return s;
  endfunction

  // Random register set, weighted toward short delays so echoes and feedback
  // come back within a phase; out-of-range targets and extreme gains included.
  function automatic delay_setup_t random_setup();
    delay_setup_t s;
    int           r;
    r = $urandom_range(0, 99);
    if (r < 50)      s.target = CFG_W'($urandom_range(32 * 256, 160 * 256));
    else if (r < 60) s.target = CFG_W'($urandom_range(0, 32 * 256 - 1));
    else if (r < 70) s.target = CFG_W'($urandom_range((LINE_DEPTH - 8) * 256 + 1,
                                                      (1 << CFG_W) - 1));
    else if (r < 75) s.target = ($urandom_range(0, 1) != 0) ? CFG_W'(32 * 256)
                                                            : CFG_W'((LINE_DEPTH - 8) * 256);
    else if (r < 85) s.target = CFG_W'($urandom_range(160 * 256, 2000 * 256));
    else             s.target = CFG_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 25)      s.ramp = '0;
    else if (r < 35) s.ramp = RAMP_W'(1);
    else if (r < 70) s.ramp = RAMP_W'($urandom_range(2, 120));
    else if (r < 80) s.ramp = '1;
    else             s.ramp = RAMP_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15)      s.fb = '0;
    else if (r < 30) s.fb = GAIN_W'(32768);
    else if (r < 40) s.fb = '1;
    else if (r < 75) s.fb = GAIN_W'($urandom_range(8192, 30000));
    else             s.fb = GAIN_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15)      s.wet = '0;
    else if (r < 30) s.wet = GAIN_W'(32768);
    else if (r < 40) s.wet = '1;
    else if (r < 75) s.wet = GAIN_W'($urandom_range(8192, 30000));
    else             s.wet = GAIN_W'($urandom);
    s.pp    = 1'($urandom_range(0, 1));
    s.spare = ($urandom_range(0, 4) == 0);
    return s;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one word; returns at the edge where it is taken. in_valid stays high
  // into the next word when no gap is drawn, so it is never dropped and raised
  // in the same step.
  task automatic push_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_batch(input int count, input bit use_corners, inout int base);
    int k;
    for (k = 0; k < count; k++) begin
      push_word(use_corners ? corner_word(base + k) : noise_word());
    end
    base = base + count;
  endtask

  // Stop offering and wait until every word taken has come back. The extra
  // edge first lets the checker count the last word that went in.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  // Register writes, one per edge; upper data bits carry junk the core must
  // mask. cfg_we only drops after the last write.
  task automatic apply_setup(input delay_setup_t s);
    int k;
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DELAY_TARGET;
    cfg_wdata <= s.target;
    @(posedge clk);
    cfg_addr  <= REG_RAMP_STEPS;
    cfg_wdata <= {(CFG_W - RAMP_W)'($urandom), s.ramp};
    @(posedge clk);
    cfg_addr  <= REG_FB_GAIN;
    cfg_wdata <= {(CFG_W - GAIN_W)'($urandom), s.fb};
    @(posedge clk);
    cfg_addr  <= REG_WET_MIX;
    cfg_wdata <= {(CFG_W - GAIN_W)'($urandom), s.wet};
    @(posedge clk);
    cfg_addr  <= REG_PING_PONG;
    cfg_wdata <= {(CFG_W - 1)'($urandom), s.pp};
    @(posedge clk);
    if (s.spare) begin
      for (k = 0; k < 3; k++) begin
        cfg_addr  <= REG_SPARE + CFG_AW'(k);
        cfg_wdata <= CFG_W'($urandom);
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  // out_ready: single-cycle toggles, short and long stalls, stretches held
  // high, and two forced long hold-offs to back the core up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_left  <= 0;
      burst_left  <= 0;
      words_taken <= 0;
      holds_done  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        words_taken <= words_taken + 1;
      end
      if (holds_done < 2 && words_taken >= (holds_done + 1) * HOLD_WORDS) begin
        out_ready  <= 1'b0;
        stall_left <= LONG_HOLD;
        holds_done <= holds_done + 1;
      end else if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (burst_left > 0) begin
        out_ready  <= 1'b1;
        burst_left <= burst_left - 1;
      end else begin
        ready_pick = $urandom_range(0, 99);
        if (ready_pick < 15) begin
          out_ready  <= 1'b1;
          burst_left <= $urandom_range(20, 150);
        end else if (ready_pick < 55) begin
          out_ready <= 1'b1;
        end else if (ready_pick < 92) begin
          out_ready  <= 1'b0;
          stall_left <= $urandom_range(0, 3);
        end else begin
          out_ready  <= 1'b0;
          stall_left <= $urandom_range(8, 50);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  // Any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_count <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int base;
    int sent;
    int count;
    base        = 0;
    sent        = 0;
    sender_calm = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // Reset settings: long delay, so only the dry path shows.
    send_batch(3, 1'b1, base);
    wait_drained();
    // Target below the floor with a jump, both gains at their maximum (above
    // unity), ping-pong on, and junk written to the unused addresses.
    apply_setup(make_setup(CFG_W'(100), '0, '1, '1, 1'b1, 1'b1));
    send_batch(6, 1'b1, base);
    wait_drained();
    // Target above the ceiling with a short glide toward it.
    apply_setup(make_setup('1, RAMP_W'(8), '0, GAIN_W'(32768), 1'b0, 1'b0));
    send_batch(4, 1'b1, base);
    wait_drained();
    // New target while that glide is still running: restarts from here.
    apply_setup(make_setup(CFG_W'(40 * 256 + 128), RAMP_W'(5), GAIN_W'(32768),
                           GAIN_W'(16384), 1'b1, 1'b0));
    send_batch(6, 1'b1, base);
    wait_drained();

    // Random part: one register set per phase, some phases without sender gaps.
    while (sent < RANDOM_WORDS) begin
      apply_setup(random_setup());
      sender_calm = ($urandom_range(0, 4) == 0);
      count = $urandom_range(20, 90);
      send_batch(count, 1'b0, base);
      sent = sent + count;
      wait_drained();
    end

    repeat (QUIET_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_in_flight == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
